// File: rtl/core/key_debounce_long_press_fsm_top_defines.svh
// assertion macros for the key debounce block checker
// no dependencies; taken in by the checker file
`ifndef KEY_DEBOUNCE_LONG_PRESS_FSM_TOP_DEFINES_SVH
`define KEY_DEBOUNCE_LONG_PRESS_FSM_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define KDLP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define KDLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/kdlp_pkg.sv
// shared constants for the key debounce / long press block
// no dependencies; used by every module of the block
package kdlp_pkg;

	// parameter defaults
	localparam int KEY_BITS_DEF    = 8;
	localparam int COUNT_BITS_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 2;

	// event codes
	localparam int EV_W = 3;
	localparam logic [EV_W-1:0] EV_PRESSED   = 3'd0;
	localparam logic [EV_W-1:0] EV_LONG      = 3'd1;
	localparam logic [EV_W-1:0] EV_VLONG     = 3'd2;
	localparam logic [EV_W-1:0] EV_REL       = 3'd3;
	localparam logic [EV_W-1:0] EV_LONG_REL  = 3'd4;
	localparam logic [EV_W-1:0] EV_VLONG_REL = 3'd5;
	localparam logic [EV_W-1:0] EV_END       = 3'd6;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int PERIOD_W   = 8;
	localparam int THRESH_W   = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_LONG   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_VLONG  = 2'd2;

	// register reset values
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 8'd10;
	localparam logic [THRESH_W-1:0] LONG_RST   = 16'd1000;
	localparam logic [THRESH_W-1:0] VLONG_RST  = 16'd5000;

endpackage

// File: rtl/core/kdlp_front.sv
// front end: config registers, press state machine, event classification
// depends on kdlp_pkg; feeds one packet of up to two events per item
module kdlp_front #(
	parameter int KEY_BITS   = kdlp_pkg::KEY_BITS_DEF,
	parameter int COUNT_BITS = kdlp_pkg::COUNT_BITS_DEF,
	parameter int PKT_W      = 1 + 2 * (kdlp_pkg::EV_W + KEY_BITS)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [kdlp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kdlp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [KEY_BITS-1:0]              key_sample,
	output logic                             push,
	output logic [PKT_W-1:0]                 push_data,
	input  logic                             queue_full
);

	localparam int CMP_W = (COUNT_BITS > kdlp_pkg::THRESH_W) ? COUNT_BITS : kdlp_pkg::THRESH_W;
	localparam int EV_W  = kdlp_pkg::EV_W;

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_PRESSED = 2'd1;
	localparam logic [1:0] PH_WAIT    = 2'd2;

	logic [kdlp_pkg::PERIOD_W-1:0] period_q;
	logic [kdlp_pkg::THRESH_W-1:0] long_q;
	logic [kdlp_pkg::THRESH_W-1:0] vlong_q;

	logic [1:0]            phase_q, phase_d;
	logic [KEY_BITS-1:0]   held_q, held_d;
	logic [COUNT_BITS-1:0] cnt_q, cnt_d;
	logic [EV_W-1:0]       prev_q, prev_d;

	logic                  accept;
	logic                  has_ev, two_ev;
	logic [EV_W-1:0]       code0, code1;
	logic [KEY_BITS-1:0]   keys0, keys1;
	logic [COUNT_BITS:0]   cnt_sum;
	logic [COUNT_BITS-1:0] cnt_sat;
	logic [CMP_W-1:0]      cnt_w, long_w, vlong_w;
	logic                  at_long, at_vlong;

	// configuration writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= kdlp_pkg::PERIOD_RST;
			long_q   <= kdlp_pkg::LONG_RST;
			vlong_q  <= kdlp_pkg::VLONG_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				kdlp_pkg::CFG_IDX_PERIOD: period_q <= cfg_wdata[kdlp_pkg::PERIOD_W-1:0];
				kdlp_pkg::CFG_IDX_LONG:   long_q   <= cfg_wdata[kdlp_pkg::THRESH_W-1:0];
				kdlp_pkg::CFG_IDX_VLONG:  vlong_q  <= cfg_wdata[kdlp_pkg::THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall = queue_full;
	assign accept   = in_valid && !queue_full;

	// hold time compare and saturating advance
	always_comb begin
		cnt_w    = CMP_W'(cnt_q);
		long_w   = CMP_W'(long_q);
		vlong_w  = CMP_W'(vlong_q);
		at_long  = (cnt_w >= long_w) && (cnt_w < vlong_w);
		at_vlong = (cnt_w >= vlong_w);
		cnt_sum  = {1'b0, cnt_q} + (COUNT_BITS + 1)'(period_q);
		cnt_sat  = cnt_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : cnt_sum[COUNT_BITS-1:0];
	end

	// next state and events for one sample
	always_comb begin
		phase_d = phase_q;
		held_d  = held_q;
		cnt_d   = cnt_q;
		prev_d  = prev_q;
		has_ev  = 1'b0;
		two_ev  = 1'b0;
		code0   = kdlp_pkg::EV_PRESSED;
		keys0   = held_q;
		code1   = kdlp_pkg::EV_END;
		keys1   = held_q;
		case (phase_q)
			PH_PRESSED: begin
				if (key_sample == held_q) begin
					if (at_long && prev_q == kdlp_pkg::EV_PRESSED) begin
						has_ev = 1'b1;
						code0  = kdlp_pkg::EV_LONG;
						prev_d = kdlp_pkg::EV_LONG;
					end else if (at_vlong && prev_q == kdlp_pkg::EV_LONG) begin
						has_ev = 1'b1;
						code0  = kdlp_pkg::EV_VLONG;
						prev_d = kdlp_pkg::EV_VLONG;
					end else begin
						cnt_d = cnt_sat;
					end
				end else if (key_sample == '0) begin
					phase_d = PH_WAIT;
				end else begin
					// new keys pressed, then the ones let go; count restarts at one period
					has_ev  = 1'b1;
					two_ev  = 1'b1;
					code0   = kdlp_pkg::EV_PRESSED;
					keys0   = key_sample & ~held_q;
					code1   = kdlp_pkg::EV_REL;
					keys1   = held_q & ~key_sample;
					prev_d  = kdlp_pkg::EV_REL;
					held_d  = key_sample;
					cnt_d   = COUNT_BITS'(period_q);
					phase_d = PH_PRESSED;
				end
			end
			PH_WAIT: begin
				if (key_sample == '0) begin
					has_ev = 1'b1;
					two_ev = 1'b1;
					if (prev_q == kdlp_pkg::EV_VLONG) begin
						code0 = kdlp_pkg::EV_VLONG_REL;
					end else if (prev_q == kdlp_pkg::EV_LONG) begin
						code0 = kdlp_pkg::EV_LONG_REL;
					end else begin
						code0 = kdlp_pkg::EV_REL;
					end
					code1   = kdlp_pkg::EV_END;
					phase_d = PH_IDLE;
					prev_d  = kdlp_pkg::EV_END;
				end else begin
					has_ev  = 1'b1;
					code0   = kdlp_pkg::EV_REL;
					keys0   = held_q & ~key_sample;
					prev_d  = kdlp_pkg::EV_REL;
					held_d  = key_sample;
					cnt_d   = COUNT_BITS'(period_q);
					phase_d = PH_PRESSED;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (key_sample != '0) begin
					has_ev  = 1'b1;
					code0   = kdlp_pkg::EV_PRESSED;
					keys0   = key_sample;
					held_d  = key_sample;
					cnt_d   = '0;
					prev_d  = kdlp_pkg::EV_PRESSED;
					phase_d = PH_PRESSED;
				end
			end
		endcase
	end

	// state update on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= '0;
			cnt_q   <= '0;
			prev_q  <= kdlp_pkg::EV_END;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			cnt_q   <= cnt_d;
			prev_q  <= prev_d;
		end
	end

	assign push      = accept && has_ev;
	assign push_data = {two_ev, code0, keys0, code1, keys1};

endmodule

// File: rtl/core/kdlp_queue.sv
// small packet queue between front and back end
// depends on kdlp_pkg for the default depth
module kdlp_queue #(
	parameter int PKT_W = 1,
	parameter int DEPTH = kdlp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [PKT_W-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [PKT_W-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [PKT_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full      = (cnt_q == CNT_FULL);
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/kdlp_back.sv
// back end: unpacks a packet and drives events out one per cycle while out_stall is low
// depends on kdlp_pkg; output register plus one pending event slot
module kdlp_back #(
	parameter int KEY_BITS = kdlp_pkg::KEY_BITS_DEF,
	parameter int PKT_W    = 1 + 2 * (kdlp_pkg::EV_W + KEY_BITS)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_not_empty,
	input  logic [PKT_W-1:0]             q_data,
	output logic                         q_pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [kdlp_pkg::EV_W-1:0]    event_code,
	output logic [KEY_BITS-1:0]          event_keys,
	output logic                         last_of_run
);

	localparam int EV_W = kdlp_pkg::EV_W;

	logic                out_valid_q, last_q, pend_valid_q;
	logic [EV_W-1:0]     code_q, pend_code_q;
	logic [KEY_BITS-1:0] keys_q, pend_keys_q;
	logic                load, two_ev;
	logic [EV_W-1:0]     code0, code1;
	logic [KEY_BITS-1:0] keys0, keys1;

	assign {two_ev, code0, keys0, code1, keys1} = q_data;

	// output slot free or being taken this cycle
	assign load  = !out_valid_q || !out_stall;
	assign q_pop = load && !pend_valid_q && q_not_empty;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (load) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= q_not_empty;
				pend_valid_q <= q_not_empty && two_ev;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_valid_q) begin
				code_q <= pend_code_q;
				keys_q <= pend_keys_q;
				last_q <= 1'b1;
			end else if (q_not_empty) begin
				code_q      <= code0;
				keys_q      <= keys0;
				last_q      <= !two_ev;
				pend_code_q <= code1;
				pend_keys_q <= keys1;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign event_code  = code_q;
	assign event_keys  = keys_q;
	assign last_of_run = last_q;

endmodule

// File: rtl/core/key_debounce_long_press_fsm_top.sv
// top level of the key debounce / long press block
// depends on kdlp_pkg, kdlp_front, kdlp_queue, kdlp_back
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------
//  in      | in_valid  | in_stall  | key_sample
//  out     | out_valid | out_stall | event_code, event_keys, last_of_run
//  cfg     | cfg_wr_en | -         | cfg_index, cfg_wdata
//
// a sample is taken every cycle while the two-packet queue has room; each
// sample gives zero, one or two events, sent one per cycle from the output register while
// out_stall is low, so the output port sets the rate.
// first event of a sample is registered in the queue, then in the output register, before it is valid.
// async reset clears state machine, queue and output; config goes to defaults.
// out_stall holds the output; in_stall rises only when the queue is full.
module key_debounce_long_press_fsm_top #(
	parameter int KEY_BITS    = kdlp_pkg::KEY_BITS_DEF,
	parameter int COUNT_BITS  = kdlp_pkg::COUNT_BITS_DEF,
	parameter int QUEUE_DEPTH = kdlp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [kdlp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kdlp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [KEY_BITS-1:0]             key_sample,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [kdlp_pkg::EV_W-1:0]       event_code,
	output logic [KEY_BITS-1:0]             event_keys,
	output logic                            last_of_run
);

	localparam int PKT_W = 1 + 2 * (kdlp_pkg::EV_W + KEY_BITS);

	logic             push, q_full, q_pop, q_not_empty;
	logic [PKT_W-1:0] push_data, q_data;

	// classify samples
	kdlp_front #(
		.KEY_BITS   (KEY_BITS),
		.COUNT_BITS (COUNT_BITS),
		.PKT_W      (PKT_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.key_sample (key_sample),
		.push       (push),
		.push_data  (push_data),
		.queue_full (q_full)
	);

	// event packet queue
	kdlp_queue #(
		.PKT_W (PKT_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_data)
	);

	// serialize events
	kdlp_back #(
		.KEY_BITS (KEY_BITS),
		.PKT_W    (PKT_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_code  (event_code),
		.event_keys  (event_keys),
		.last_of_run (last_of_run)
	);

endmodule

// File: rtl/core/kdlp_checker.sv
// port-level checker for the key debounce block, bound to the top level
// depends on kdlp_pkg and key_debounce_long_press_fsm_top_defines.svh
`include "key_debounce_long_press_fsm_top_defines.svh"

module kdlp_checker #(
	parameter int KEY_BITS = kdlp_pkg::KEY_BITS_DEF
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [kdlp_pkg::EV_W-1:0] event_code,
	input logic [KEY_BITS-1:0]       event_keys,
	input logic                      last_of_run
);

	logic rel_first;

	// a release-type event that is not last must be followed by the end event
	assign rel_first = out_valid && !out_stall && !last_of_run &&
		(event_code == kdlp_pkg::EV_REL || event_code == kdlp_pkg::EV_LONG_REL ||
		event_code == kdlp_pkg::EV_VLONG_REL);

	// stalled output holds
	`KDLP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(event_code) && $stable(event_keys) && $stable(last_of_run), "stalled event changed")

	// end event closes the run and names the held keys
	`KDLP_ASSERT_IMPLY(a_end_last, clk, arst_n, out_valid && event_code == kdlp_pkg::EV_END, last_of_run && event_keys != '0, "end event not last or empty")

	// second event of a pair follows at once
	`KDLP_ASSERT_NEXT(a_pair_next, clk, arst_n, out_valid && !out_stall && !last_of_run, out_valid, "second event of a sample missing")

	// release followed by end
	`KDLP_ASSERT_NEXT(a_rel_end, clk, arst_n, rel_first, out_valid && event_code == kdlp_pkg::EV_END, "release not followed by end")

endmodule

bind key_debounce_long_press_fsm_top kdlp_checker #(
	.KEY_BITS (KEY_BITS)
) u_kdlp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.event_code  (event_code),
	.event_keys  (event_keys),
	.last_of_run (last_of_run)
);

// File: tb/sv/tb_key_debounce_long_press_fsm_top.sv
// self-checking bench for the key debounce / long press block
// depends on kdlp_pkg and key_debounce_long_press_fsm_top; holds the event predictor
// scoreboard class and the top module that drives samples and settings
`timescale 1ns / 100ps

import kdlp_pkg::*;

localparam int KEY_W = KEY_BITS_DEF;
localparam int CNT_W = COUNT_BITS_DEF;

typedef enum logic [1:0] {
	ST_IDLE    = 2'd0,
	ST_PRESSED = 2'd1,
	ST_WAIT    = 2'd2
} key_phase_e;

typedef struct packed {
	logic [EV_W-1:0]  code;
	logic [KEY_W-1:0] keys;
	logic             last;
} key_event_t;

// predicts events from accepted samples and checks them in order
class key_event_scoreboard;
	key_event_t       pending_q[$];
	key_event_t       step_q[$];
	key_phase_e       phase;
	logic [KEY_W-1:0] held;
	logic [CNT_W-1:0] hold_cnt;
	logic [EV_W-1:0]  prev_code;
	logic [7:0]       period;
	logic [15:0]      long_th;
	logic [15:0]      vlong_th;
	int               errors;
	int               checked;
	int               samples;
	int               code_hits [7];

	function new();
		phase     = ST_IDLE;
		held      = '0;
		hold_cnt  = '0;
		prev_code = EV_END;
		period    = PERIOD_RST;
		long_th   = LONG_RST;
		vlong_th  = VLONG_RST;
		errors    = 0;
		checked   = 0;
		samples   = 0;
		foreach (code_hits[i]) code_hits[i] = 0;
	endfunction

	function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_IDX_PERIOD: period = data[PERIOD_W-1:0];
			CFG_IDX_LONG:   long_th = data[THRESH_W-1:0];
			CFG_IDX_VLONG:  vlong_th = data[THRESH_W-1:0];
			default: ;
		endcase
	endfunction

	function int pending();
		return pending_q.size();
	endfunction

	// at most two events per sample
	function void push_event(logic [EV_W-1:0] code, logic [KEY_W-1:0] keys);
		key_event_t ev;
		ev.code = code;
		ev.keys = keys;
		ev.last = 1'b0;
		if (step_q.size() < 2) step_q.push_back(ev);
	endfunction

	// same key set held: long, very long, or count the hold time
	function void hold_tick();
		logic [CNT_W:0] sum;
		if (hold_cnt >= long_th && hold_cnt < vlong_th && prev_code == EV_PRESSED) begin
			push_event(EV_LONG, held);
			prev_code = EV_LONG;
		end else if (hold_cnt >= vlong_th && prev_code == EV_LONG) begin
			push_event(EV_VLONG, held);
			prev_code = EV_VLONG;
		end else begin
			sum = {1'b0, hold_cnt} + period;
			hold_cnt = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
		end
	endfunction

	// waiting for release: full release ends the run, otherwise relatch
	function void release_step(logic [KEY_W-1:0] s);
		logic [EV_W-1:0] code;
		if (s == '0) begin
			code = EV_REL;
			if (prev_code == EV_VLONG) code = EV_VLONG_REL;
			else if (prev_code == EV_LONG) code = EV_LONG_REL;
			push_event(code, held);
			push_event(EV_END, held);
			phase = ST_IDLE;
			prev_code = EV_END;
		end else begin
			push_event(EV_REL, held & ~s);
			prev_code = EV_REL;
			held = s;
			hold_cnt = '0;
			phase = ST_PRESSED;
			hold_tick();
		end
	endfunction

	function void note_sample(logic [KEY_W-1:0] s);
		step_q.delete();
		samples++;
		case (phase)
			ST_PRESSED: begin
				if (s == held) begin
					hold_tick();
				end else if (s == '0) begin
					phase = ST_WAIT;
				end else begin
					push_event(EV_PRESSED, s & ~held);
					phase = ST_WAIT;
					release_step(s);
				end
			end
			ST_WAIT: release_step(s);
			default: begin
				phase = ST_IDLE;
				if (s != '0) begin
					held = s;
					hold_cnt = '0;
					push_event(EV_PRESSED, s);
					prev_code = EV_PRESSED;
					phase = ST_PRESSED;
				end
			end
		endcase
		if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
		foreach (step_q[i]) pending_q.push_back(step_q[i]);
	endfunction

	task report_mismatch(string what);
		errors++;
		$display("[%0t] ERROR %s", $time, what);
	endtask

	task check_event(logic [EV_W-1:0] code, logic [KEY_W-1:0] keys, logic last);
		key_event_t want;
		if (pending_q.size() == 0) begin
			report_mismatch($sformatf("unexpected event code %0d keys %h last %b",
				code, keys, last));
		end else begin
			want = pending_q.pop_front();
			checked++;
			if (code <= EV_END) code_hits[code]++;
			if (code !== want.code)
				report_mismatch($sformatf("event_code %0d, predicted %0d", code, want.code));
			if (keys !== want.keys)
				report_mismatch($sformatf("event_keys %h, predicted %h", keys, want.keys));
			if (last !== want.last)
				report_mismatch($sformatf("last_of_run %b, predicted %b", last, want.last));
		end
	endtask
endclass

module tb_key_debounce_long_press_fsm_top;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 8;

	// short directed sweep run with period 5, long 10, very long 20
	localparam logic [KEY_W-1:0] DIRECTED [26] = '{
		8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
		8'h01, 8'h03, 8'h02, 8'h00, 8'h80, 8'h00, 8'h00,
		8'hFF, 8'h00, 8'h00,
		8'h55, 8'h55, 8'h55, 8'h55, 8'h00, 8'h00
	};

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  cfg_wr_en  = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = CFG_IDX_PERIOD;
	logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
	logic                  in_valid   = 1'b0;
	logic                  in_stall;
	logic [KEY_W-1:0]      key_sample = '0;
	logic                  out_valid;
	logic                  out_stall  = 1'b0;
	logic [EV_W-1:0]       event_code;
	logic [KEY_W-1:0]      event_keys;
	logic                  last_of_run;

	key_event_scoreboard sb;
	bit idle_en = 1'b1;
	int items_sent = 0;
	int settings_used = 0;

	key_debounce_long_press_fsm_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.key_sample (key_sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_code (event_code),
		.event_keys (event_keys),
		.last_of_run(last_of_run)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// event monitor and random output stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_event(event_code, event_keys, last_of_run);
		out_stall <= idle_en && ($urandom_range(0, 99) < 24);
	end

	// watchdog: ends the run when no handshake happens for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
			else quiet++;
		end
		$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// one sample item, with an optional random gap in front
	task automatic send_sample(input logic [KEY_W-1:0] s);
		if (idle_en && $urandom_range(0, 99) < 24) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 24);
		end
		in_valid <= 1'b1;
		key_sample <= s;
		do @(posedge clk); while (in_stall);
		sb.note_sample(s);
		items_sent++;
	endtask

	// hold the sender until every predicted event is out, then let the block settle
	task automatic drain_events();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all three registers; junk lands in the unused upper period bits
	task automatic load_settings(input logic [7:0] period, input logic [15:0] long_th,
			input logic [15:0] vlong_th, input logic [7:0] junk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_IDX_PERIOD;
		cfg_wdata <= {junk, period};
		@(posedge clk);
		cfg_index <= CFG_IDX_LONG;
		cfg_wdata <= long_th;
		@(posedge clk);
		cfg_index <= CFG_IDX_VLONG;
		cfg_wdata <= vlong_th;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_register(CFG_IDX_PERIOD, {junk, period});
		sb.set_register(CFG_IDX_LONG, long_th);
		sb.set_register(CFG_IDX_VLONG, vlong_th);
		settings_used++;
	endtask

	// press, hold, maybe change keys or bounce through zero, then release
	task automatic press_run(input logic [KEY_W-1:0] keys, input int hold);
		logic [KEY_W-1:0] other;
		int pick;
		send_sample(keys);
		repeat (hold) send_sample(keys);
		pick = $urandom_range(0, 99);
		other = KEY_W'($urandom_range(1, 255));
		if (pick < 30) begin
			send_sample(other);
			repeat (hold) send_sample(other);
		end else if (pick < 50) begin
			send_sample('0);
			send_sample(other);
			repeat (hold) send_sample(other);
		end
		send_sample('0);
		if ($urandom_range(0, 9) != 0) send_sample('0);
	endtask

	// mostly well-formed press runs, some noise, now and then a full drain
	task automatic run_phase(input int count, input int max_hold);
		int target;
		int n;
		target = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(0, 99) < 70) begin
				press_run(KEY_W'($urandom_range(1, 255)), $urandom_range(0, max_hold));
			end else begin
				n = $urandom_range(1, 4);
				repeat (n)
					send_sample($urandom_range(0, 1) ? KEY_W'($urandom_range(0, 255)) : '0);
			end
			if ($urandom_range(0, 99) < 3) drain_events();
		end
		drain_events();
	endtask

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed sweep over every event code and delta case
		load_settings(8'd5, 16'd10, 16'd20, 8'h00);
		foreach (DIRECTED[i]) send_sample(DIRECTED[i]);
		drain_events();

		// period of one, long press right away
		load_settings(8'd1, 16'd0, 16'd3, 8'h00);
		run_phase(80, 8);

		// hold count runs into saturation before the very long press
		load_settings(8'd250, 16'd64000, 16'hFFFF, 8'h00);
		send_sample(8'hA5);
		repeat (268) send_sample(8'hA5);
		send_sample('0);
		send_sample('0);
		run_phase(20, 4);

		// zero period never advances the count
		load_settings(8'd0, 16'd0, 16'd1, 8'h00);
		run_phase(60, 6);

		// largest period with garbage upper bits, long threshold out of reach
		load_settings(8'd255, 16'hFFFF, 16'd0, KEY_W'($urandom_range(1, 255)));
		run_phase(60, 6);

		// mid settings with no idling on either side
		idle_en = 1'b0;
		load_settings(8'd37, 16'd150, 16'd400, 8'h00);
		run_phase(90, 14);
		idle_en = 1'b1;

		load_settings(8'd3, 16'd20, 16'd60, 8'h00);
		run_phase(90, 25);

		drain_events();
		while (sb.pending() != 0) begin
			void'(sb.pending_q.pop_front());
			sb.report_mismatch("predicted event never arrived");
		end

		$display("covered %0d samples under %0d register settings, %0d events checked",
			sb.samples, settings_used, sb.checked);
		$display("events seen: press %0d long %0d vlong %0d rel %0d lrel %0d vlrel %0d end %0d",
			sb.code_hits[0], sb.code_hits[1], sb.code_hits[2], sb.code_hits[3],
			sb.code_hits[4], sb.code_hits[5], sb.code_hits[6]);
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
